### rtl/core/tcps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcps_pkg
// Shared types and codes of the threshold-crossing p-value search.
// ----------------------------------------------------------------------------
package tcps_pkg;

    localparam int CNT_W  = 11;
    localparam int INV_W  = 17;
    localparam int PVAL_W = 17;
    localparam int DATA_W = 32;
    localparam int SLOT_W = 10;
    localparam int CMD_W  = 2;
    localparam int PADDR_W = 4;

    localparam logic [CMD_W-1:0] CMD_LOAD_PAIR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_CRIT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START     = 2'd2;

    localparam logic [1:0] REG_PAIR_COUNT      = 2'd0;
    localparam logic [1:0] REG_THRESHOLD_COUNT = 2'd1;
    localparam logic [1:0] REG_INV_SQRT_N      = 2'd2;

    localparam logic [INV_W-1:0]  INV_ONE  = 17'd65536;
    localparam logic [PVAL_W-1:0] PVAL_ONE = 17'd65536;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_ONE  = 2'd1,
        SRC_DIV  = 2'd2
    } out_src_t;

    typedef struct packed {
        logic             load_pair;
        logic             load_crit;
        logic             eval_go;
        logic [CNT_W-1:0] eval_idx;
        logic             div_go;
        logic [CNT_W-1:0] div_idx;
        logic [CNT_W-1:0] div_r;
        logic             out_load;
        out_src_t         out_src;
        logic [CNT_W-1:0] out_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic eval_done;
        logic theta_pos;
        logic div_done;
        logic out_full;
    } dp_status_t;

endpackage : tcps_pkg
`default_nettype wire

### rtl/core/tcps_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcps_in_if / tcps_out_if
// Valid/ready channels for commands in and results out.
// ----------------------------------------------------------------------------
interface tcps_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [9:0]  slot;
    logic [31:0] h_value;
    logic [31:0] sigma_value;
    logic [31:0] crit_value;

    modport source (output valid, cmd, slot, h_value, sigma_value, crit_value,
                    input ready);
    modport sink (input valid, cmd, slot, h_value, sigma_value, crit_value,
                  output ready);
endinterface : tcps_in_if

interface tcps_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] p_value;
    logic [10:0] cross_index;

    modport source (output valid, p_value, cross_index, input ready);
    modport sink (input valid, p_value, cross_index, output ready);
endinterface : tcps_out_if
`default_nettype wire

### rtl/core/tcps_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcps_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tcps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule : tcps_ram
`default_nettype wire

### rtl/core/tcps_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcps_datapath
// Stores, pipelined theta evaluation, p-value divider and result register.
// ----------------------------------------------------------------------------
module tcps_datapath #(
    parameter int MAX_PAIRS      = 1024,
    parameter int MAX_THRESHOLDS = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire tcps_pkg::dp_cmd_t         cmd,
    output tcps_pkg::dp_status_t           status,
    input  wire logic [9:0]                slot,
    input  wire logic [31:0]               h_value,
    input  wire logic [31:0]               sigma_value,
    input  wire logic [31:0]               crit_value,
    input  wire logic [10:0]               pair_count,
    input  wire logic [16:0]               inv_sqrt_n,
    tcps_out_if.source                     out_ch
);
    import tcps_pkg::*;

    localparam int PAW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CAW = (MAX_THRESHOLDS > 1) ? $clog2(MAX_THRESHOLDS) : 1;
    localparam int NUM_W = CNT_W + 16;
    localparam int DCNT_W = $clog2(NUM_W + 1);

    typedef enum logic [3:0] {
        EV_IDLE   = 4'b0001,
        EV_KWAIT  = 4'b0010,
        EV_STREAM = 4'b0100,
        EV_DRAIN  = 4'b1000
    } ev_state_t;

    // ---- stores ------------------------------------------------------------
    logic [63:0]      pair_q;
    logic [31:0]      crit_q;
    logic [PAW-1:0]   pair_rd_addr;
    logic [CAW-1:0]   crit_rd_addr;
    logic [CAW-1:0]   crit_addr_reg, crit_addr_next;
    logic             pair_wr, crit_wr;

    assign pair_wr = cmd.load_pair && (32'(slot) < MAX_PAIRS);
    assign crit_wr = cmd.load_crit && (32'(slot) < MAX_THRESHOLDS);

    tcps_ram #(.WIDTH(64), .DEPTH(MAX_PAIRS)) u_pair_ram (
        .clk     (clk),
        .wr_en   (pair_wr),
        .wr_addr (PAW'(slot)),
        .wr_data ({h_value, sigma_value}),
        .rd_addr (pair_rd_addr),
        .rd_data (pair_q)
    );

    tcps_ram #(.WIDTH(32), .DEPTH(MAX_THRESHOLDS)) u_crit_ram (
        .clk     (clk),
        .wr_en   (crit_wr),
        .wr_addr (CAW'(slot)),
        .wr_data (crit_value),
        .rd_addr (crit_rd_addr),
        .rd_data (crit_q)
    );

    assign crit_addr_next = cmd.eval_go ? CAW'(cmd.eval_idx) : crit_addr_reg;
    assign crit_rd_addr   = crit_addr_next;

    // ---- theta evaluation ----------------------------------------------------
    ev_state_t          ev_state_reg, ev_state_next;
    logic [CNT_W-1:0]   pcnt_reg, pcnt_next;
    logic [CNT_W-1:0]   n_pairs;
    logic [INV_W-1:0]   inv_sat;
    logic               issue;
    logic               v1_reg, v2_reg, v3_reg;
    logic               ev_done_reg, ev_done_next;
    logic signed [31:0] k_reg;
    logic signed [31:0] h1_reg, h2_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] mul_reg;
    logic signed [63:0] min_reg, min_next;
    logic signed [63:0] val;
    logic signed [65:0] mul_full;

    assign n_pairs = (32'(pair_count) > MAX_PAIRS) ? CNT_W'(MAX_PAIRS) : pair_count;
    assign inv_sat = (inv_sqrt_n > INV_ONE) ? INV_ONE : inv_sqrt_n;
    assign pair_rd_addr = PAW'(pcnt_reg);
    assign issue = (ev_state_reg == EV_STREAM) && (pcnt_reg < n_pairs);

    assign mul_full = $signed(prod_reg[63:16]) * $signed({1'b0, inv_sat});
    assign val = $signed({{16{h2_reg[31]}}, h2_reg, 16'b0}) + mul_reg;

    always_comb
    begin
        ev_state_next = ev_state_reg;
        pcnt_next     = pcnt_reg;
        ev_done_next  = 1'b0;
        min_next      = min_reg;
        if (v3_reg && (val < min_reg))
        begin
            min_next = val;
        end
        unique case (ev_state_reg)
            EV_IDLE:
            begin
                if (cmd.eval_go)
                begin
                    ev_state_next = EV_KWAIT;
                    min_next      = 64'sh7FFF_FFFF_FFFF_FFFF;
                end
            end
            EV_KWAIT:
            begin
                pcnt_next     = '0;
                ev_state_next = EV_STREAM;
            end
            EV_STREAM:
            begin
                if (issue)
                begin
                    pcnt_next = pcnt_reg + 1'b1;
                end
                else
                begin
                    ev_state_next = EV_DRAIN;
                end
            end
            EV_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                begin
                    ev_done_next  = 1'b1;
                    ev_state_next = EV_IDLE;
                end
            end
            default:
            begin
                ev_state_next = EV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_state_reg  <= EV_IDLE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            ev_done_reg   <= 1'b0;
            crit_addr_reg <= '0;
            pcnt_reg      <= '0;
        end
        else
        begin
            ev_state_reg  <= ev_state_next;
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            ev_done_reg   <= ev_done_next;
            crit_addr_reg <= crit_addr_next;
            pcnt_reg      <= pcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_state_reg == EV_KWAIT)
        begin
            k_reg <= $signed(crit_q);
        end
        prod_reg <= k_reg * $signed(pair_q[31:0]);
        h1_reg   <= $signed(pair_q[63:32]);
        mul_reg  <= mul_full[63:0];
        h2_reg   <= h1_reg;
        min_reg  <= min_next;
    end

    // ---- p-value divider, one quotient bit per cycle ------------------------
    logic                 div_busy_reg;
    logic                 div_done_reg;
    logic [DCNT_W-1:0]    dcnt_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     den_reg;
    logic [CNT_W:0]       trial;
    logic                 qbit;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            dcnt_reg     <= '0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (cmd.div_go)
            begin
                div_busy_reg <= 1'b1;
                dcnt_reg     <= DCNT_W'(NUM_W);
            end
            else if (div_busy_reg)
            begin
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == DCNT_W'(1))
                begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_go)
        begin
            num_reg <= {cmd.div_r - cmd.div_idx, 16'b0};
            den_reg <= cmd.div_r;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= qbit ? CNT_W'(trial - {1'b0, den_reg}) : trial[CNT_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], qbit};
        end
    end

    // ---- result register -----------------------------------------------------
    logic              out_valid_reg;
    logic [PVAL_W-1:0] out_p_reg;
    logic [CNT_W-1:0]  out_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_idx_reg <= cmd.out_idx;
            unique case (cmd.out_src)
                SRC_ZERO: out_p_reg <= '0;
                SRC_ONE:  out_p_reg <= PVAL_ONE;
                SRC_DIV:  out_p_reg <= quo_reg[PVAL_W-1:0];
                default:  out_p_reg <= '0;
            endcase
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.p_value     = out_p_reg;
    assign out_ch.cross_index = out_idx_reg;

    assign status.eval_done = ev_done_reg;
    assign status.theta_pos = (min_reg > 64'sd0);
    assign status.div_done  = div_done_reg;
    assign status.out_full  = out_valid_reg;
endmodule : tcps_datapath
`default_nettype wire

### rtl/core/tcps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcps_ctrl
// Search sequencer: top check, downward scan, bottom check, binary search.
// ----------------------------------------------------------------------------
module tcps_ctrl #(
    parameter int MAX_THRESHOLDS = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [1:0]             in_cmd,
    output logic                        in_ready,
    input  wire logic [10:0]            threshold_count,
    output tcps_pkg::dp_cmd_t           cmd,
    input  wire tcps_pkg::dp_status_t   status
);
    import tcps_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_TOP    = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_BOTTOM = 7'b0001000,
        S_BIN    = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] eidx_reg, eidx_next;
    logic [CNT_W-1:0] res_idx_reg, res_idx_next;
    out_src_t         src_reg, src_next;
    logic             eval_go_reg, eval_go_next;
    logic             div_go_reg, div_go_next;
    logic [CNT_W-1:0] r_sat;
    logic [CNT_W-1:0] blo, bhi;
    logic [CNT_W:0]   bsum;
    logic             accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign r_sat = (32'(threshold_count) > MAX_THRESHOLDS) ? CNT_W'(MAX_THRESHOLDS)
                                                           : threshold_count;

    // bounds after one binary step
    assign blo  = status.theta_pos ? lo_reg : eidx_reg;
    assign bhi  = status.theta_pos ? eidx_reg : hi_reg;
    assign bsum = {1'b0, blo} + {1'b0, bhi};

    always_comb
    begin
        state_next   = state_reg;
        r_next       = r_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        j_next       = j_reg;
        eidx_next    = eidx_reg;
        res_idx_next = res_idx_reg;
        src_next     = src_reg;
        eval_go_next = 1'b0;
        div_go_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_cmd == CMD_START))
                begin
                    r_next = r_sat;
                    if (r_sat == '0)
                    begin
                        res_idx_next = '0;
                        src_next     = SRC_ONE;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        eidx_next    = r_sat - 1'b1;
                        eval_go_next = 1'b1;
                        state_next   = S_TOP;
                    end
                end
            end
            S_TOP:
            begin
                if (status.eval_done)
                begin
                    if (status.theta_pos)
                    begin
                        eidx_next    = '0;
                        eval_go_next = 1'b1;
                        state_next   = S_BOTTOM;
                    end
                    else if (eidx_reg == '0)
                    begin
                        res_idx_next = r_reg;
                        src_next     = SRC_ONE;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        j_next       = eidx_reg - 1'b1;
                        eidx_next    = eidx_reg - 1'b1;
                        eval_go_next = 1'b1;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (status.eval_done)
                begin
                    if (status.theta_pos)
                    begin
                        res_idx_next = j_reg + 1'b1;
                        div_go_next  = 1'b1;
                        state_next   = S_DIV;
                    end
                    else if (j_reg == '0)
                    begin
                        res_idx_next = r_reg;
                        src_next     = SRC_ONE;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        j_next       = j_reg - 1'b1;
                        eidx_next    = j_reg - 1'b1;
                        eval_go_next = 1'b1;
                    end
                end
            end
            S_BOTTOM:
            begin
                if (status.eval_done)
                begin
                    if (status.theta_pos)
                    begin
                        res_idx_next = '0;
                        src_next     = SRC_ZERO;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        lo_next = '0;
                        hi_next = r_reg - 1'b1;
                        if ((r_reg - 1'b1) > CNT_W'(1))
                        begin
                            eidx_next    = CNT_W'(({1'b0, r_reg} - 1'b1) >> 1);
                            eval_go_next = 1'b1;
                            state_next   = S_BIN;
                        end
                        else
                        begin
                            res_idx_next = r_reg - 1'b1;
                            div_go_next  = 1'b1;
                            state_next   = S_DIV;
                        end
                    end
                end
            end
            S_BIN:
            begin
                if (status.eval_done)
                begin
                    lo_next = blo;
                    hi_next = bhi;
                    if (({1'b0, blo} + 1'b1) < {1'b0, bhi})
                    begin
                        eidx_next    = bsum[CNT_W:1];
                        eval_go_next = 1'b1;
                    end
                    else
                    begin
                        res_idx_next = bhi;
                        div_go_next  = 1'b1;
                        state_next   = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    src_next   = SRC_DIV;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!status.out_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            eval_go_reg <= 1'b0;
            div_go_reg  <= 1'b0;
            lo_reg      <= '0;
            hi_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            eval_go_reg <= eval_go_next;
            div_go_reg  <= div_go_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg       <= r_next;
        j_reg       <= j_next;
        eidx_reg    <= eidx_next;
        res_idx_reg <= res_idx_next;
        src_reg     <= src_next;
    end

    assign cmd.load_pair = accept && (in_cmd == CMD_LOAD_PAIR);
    assign cmd.load_crit = accept && (in_cmd == CMD_LOAD_CRIT);
    assign cmd.eval_go   = eval_go_reg;
    assign cmd.eval_idx  = eidx_reg;
    assign cmd.div_go    = div_go_reg;
    assign cmd.div_idx   = res_idx_reg;
    assign cmd.div_r     = r_reg;
    assign cmd.out_load  = (state_reg == S_OUT) && !status.out_full;
    assign cmd.out_src   = src_reg;
    assign cmd.out_idx   = res_idx_reg;
endmodule : tcps_ctrl
`default_nettype wire

### rtl/core/threshold_crossing_pvalue_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// threshold_crossing_pvalue_search
// Finds the first critical value at which min(h + k*sigma*inv_sqrt_n) turns
// positive and reports the p-value 1 - index/R.
//
//   channel  dir  transfer           payload
//   in_ch    in   valid & ready      cmd, slot, h_value, sigma_value, crit_value
//   out_ch   out  valid & ready      p_value, cross_index
//   apb      in   psel&penable&pwrite pair_count, threshold_count, inv_sqrt_n
//
// Loads stream back to back. A start holds in_ch.ready low until its result
// sits in the output register. Each theta evaluation reads the pairs
// through the pair memory read port; a search does up to log2(R)+2
// evaluations (or R on the downward scan), plus a pass of the shift-subtract
// divider. Reset is asynchronous; no clearing pass. A stalled result holds,
// and loads are still taken while it waits.
// ----------------------------------------------------------------------------
module threshold_crossing_pvalue_search #(
    parameter int MAX_PAIRS      = 1024,
    parameter int MAX_THRESHOLDS = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    tcps_in_if.sink                             in_ch,
    tcps_out_if.source                          out_ch,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tcps_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);
    import tcps_pkg::*;

    logic [CNT_W-1:0] pair_count_reg;
    logic [CNT_W-1:0] threshold_count_reg;
    logic [INV_W-1:0] inv_sqrt_n_reg;
    logic             cfg_wr;
    dp_cmd_t          cmd;
    dp_status_t       status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_count_reg      <= CNT_W'(1);
            threshold_count_reg <= CNT_W'(1);
            inv_sqrt_n_reg      <= INV_ONE;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_PAIR_COUNT:      pair_count_reg      <= pwdata[CNT_W-1:0];
                REG_THRESHOLD_COUNT: threshold_count_reg <= pwdata[CNT_W-1:0];
                REG_INV_SQRT_N:      inv_sqrt_n_reg      <= pwdata[INV_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PAIR_COUNT:      prdata = 32'(pair_count_reg);
            REG_THRESHOLD_COUNT: prdata = 32'(threshold_count_reg);
            REG_INV_SQRT_N:      prdata = 32'(inv_sqrt_n_reg);
            default:             prdata = '0;
        endcase
    end

    tcps_ctrl #(.MAX_THRESHOLDS(MAX_THRESHOLDS)) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_ch.valid),
        .in_cmd          (in_ch.cmd),
        .in_ready        (in_ch.ready),
        .threshold_count (threshold_count_reg),
        .cmd             (cmd),
        .status          (status)
    );

    tcps_datapath #(
        .MAX_PAIRS      (MAX_PAIRS),
        .MAX_THRESHOLDS (MAX_THRESHOLDS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .slot        (in_ch.slot),
        .h_value     (in_ch.h_value),
        .sigma_value (in_ch.sigma_value),
        .crit_value  (in_ch.crit_value),
        .pair_count  (pair_count_reg),
        .inv_sqrt_n  (inv_sqrt_n_reg),
        .out_ch      (out_ch)
    );
endmodule : threshold_crossing_pvalue_search
`default_nettype wire

### rtl/core/tcps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcps_checker
// Port-level checks of the p-value search, bound to the top level.
// ----------------------------------------------------------------------------
module tcps_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [1:0]  in_cmd,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [16:0] p_value,
    input wire logic [10:0] cross_index
);
    import tcps_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(p_value)
                                    && $stable(cross_index))
        else $error("stalled result changed");

    // a start blocks the next transfer
    a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_cmd == CMD_START) |=> !in_ready)
        else $error("input taken during a search");

    a_p_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> p_value <= PVAL_ONE)
        else $error("p-value above one");

    // a crossing at the first index means p of zero, or no values at all
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cross_index == '0) |-> (p_value == '0) || (p_value == PVAL_ONE))
        else $error("index zero with fractional p-value");
endmodule : tcps_checker

bind threshold_crossing_pvalue_search tcps_checker u_tcps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_cmd      (in_ch.cmd),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .p_value     (out_ch.p_value),
    .cross_index (out_ch.cross_index)
);
`default_nettype wire

### tb/threshold_crossing_pvalue_search_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_crossing_pvalue_search_test
// Loads pairs and critical values, runs searches under several register
// settings and checks every p-value and crossing index against an in-bench
// model of the search or a directed expectation. Both channels idle at random.
// ----------------------------------------------------------------------------
module threshold_crossing_pvalue_search_test;
    import tcps_pkg::*;

    localparam int DEPTH = 1024;
    localparam int FILL_SLOTS = 16;
    localparam int RANDOM_ITEMS = 540;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       h;
        logic [31:0]       sigma;
        logic [31:0]       crit;
        bit                typed;
        logic [16:0]       p;
        logic [10:0]       idx;
    } cmd_item_t;

    typedef struct {
        logic [16:0] p;
        logic [10:0] idx;
    } pval_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    tcps_in_if  in_ch ();
    tcps_out_if out_ch ();

    threshold_crossing_pvalue_search i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model state
    logic signed [31:0] h_mem [DEPTH];
    logic signed [31:0] sigma_mem [DEPTH];
    logic signed [31:0] crit_mem [DEPTH];
    logic [10:0] pair_cnt;
    logic [10:0] thr_cnt;
    logic [16:0] inv_reg;

    pval_t pending_pvals [$];
    int errors;
    bit long_hold;
    int random_sent;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #50ms;
        $display("threshold_crossing_pvalue_search_test: FAIL");
        $finish;
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic longint theta_of(input logic signed [31:0] k);
        longint min_val;
        longint prod;
        longint term;
        longint inv;
        int n;
        min_val = 64'sh7FFF_FFFF_FFFF_FFFF;
        n = (pair_cnt > DEPTH) ? DEPTH : pair_cnt;
        inv = (inv_reg > 17'd65536) ? 65536 : longint'(inv_reg);
        for (int i = 0; i < n; i++)
        begin
            prod = longint'(k) * longint'(sigma_mem[i]);
            term = (longint'(h_mem[i]) <<< 16) + (prod >>> 16) * inv;
            if (term < min_val)
                min_val = term;
        end
        return min_val;
    endfunction

    function automatic pval_t search_pval();
        pval_t res;
        int r;
        int lo;
        int hi;
        int mid;
        int j;
        r = (thr_cnt > DEPTH) ? DEPTH : thr_cnt;
        if (r == 0)
        begin
            res.p = PVAL_ONE;
            res.idx = '0;
            return res;
        end
        hi = r;
        if (theta_of(crit_mem[r-1]) <= 0)
        begin
            // walk down for the last positive index
            j = r - 1;
            while (j > 0)
            begin
                j--;
                if (theta_of(crit_mem[j]) > 0)
                begin
                    hi = j + 1;
                    break;
                end
            end
        end
        else if (theta_of(crit_mem[0]) > 0)
            hi = 0;
        else
        begin
            lo = 0;
            hi = r - 1;
            while (lo + 1 < hi)
            begin
                mid = (lo + hi) / 2;
                if (theta_of(crit_mem[mid]) > 0)
                    hi = mid;
                else
                    lo = mid;
            end
        end
        res.idx = 11'(hi);
        // bottom already positive gives zero, no crossing at all gives one
        if (hi == 0)
            res.p = '0;
        else if (hi == r)
            res.p = PVAL_ONE;
        else
            res.p = 17'((longint'(r - hi) * 65536) / r);
        return res;
    endfunction

    function automatic void apply_cmd(input cmd_item_t it);
        case (it.cmd)
            CMD_LOAD_PAIR:
            begin
                h_mem[it.slot] = it.h;
                sigma_mem[it.slot] = it.sigma;
            end
            CMD_LOAD_CRIT: crit_mem[it.slot] = it.crit;
            CMD_START:
            begin
                if (it.typed)
                    pending_pvals.push_back('{p: it.p, idx: it.idx});
                else
                    pending_pvals.push_back(search_pval());
            end
            default: ;
        endcase
    endfunction

    task automatic send(input cmd_item_t it);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= it.cmd;
        in_ch.slot <= it.slot;
        in_ch.h_value <= it.h;
        in_ch.sigma_value <= it.sigma;
        in_ch.crit_value <= it.crit;
        do
            @(posedge clk);
        while (!in_ch.ready);
        apply_cmd(it);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_pvals.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (reg_idx)
            REG_PAIR_COUNT:      pair_cnt = data[10:0];
            REG_THRESHOLD_COUNT: thr_cnt = data[10:0];
            default:             inv_reg = data[16:0];
        endcase
    endtask

    task automatic configure(input int pc, input int r, input int inv);
        drain();
        apb_write(REG_PAIR_COUNT, pc);
        apb_write(REG_THRESHOLD_COUNT, r);
        apb_write(REG_INV_SQRT_N, inv);
    endtask

    function automatic cmd_item_t make(input logic [1:0] cmd, input int slot,
                                       input logic [31:0] h, input logic [31:0] s,
                                       input logic [31:0] c);
        cmd_item_t it;
        it.cmd = cmd;
        it.slot = slot;
        it.h = h;
        it.sigma = s;
        it.crit = c;
        it.typed = 1'b0;
        it.p = '0;
        it.idx = '0;
        return it;
    endfunction

    // well-formed pair: non-positive h, mostly positive sigma
    function automatic cmd_item_t rand_pair(input int slot);
        logic [31:0] s;
        s = $urandom_range(1, 1 << 18);
        if ($urandom_range(0, 7) == 0)
            s = -s;
        return make(CMD_LOAD_PAIR, slot, -$urandom_range(0, 1 << 20), s, $urandom);
    endfunction

    task automatic random_phase(input int pc, input int r, input int inv,
                                input int n_items, input bit stress);
        int sent;
        int span;
        int base;
        int step;
        int n_loads;
        configure(pc, r, inv);
        sent = 0;
        span = (pc > r) ? pc : r;
        if (span > 16)
            span = 16;
        if (span < 1)
            span = 1;
        if (stress)
            long_hold = 1'b1;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                // full reload of an ascending set
                base = $urandom_range(0, 1 << 21) - (1 << 20);
                step = $urandom_range(1, 1 << 16);
                for (int i = 0; i < span; i++)
                begin
                    send(rand_pair(i));
                    send(make(CMD_LOAD_CRIT, i, $urandom, $urandom, base + i * step));
                    sent += 2;
                end
            end
            else
            begin
                n_loads = $urandom_range(0, 4);
                for (int i = 0; i < n_loads; i++)
                begin
                    if ($urandom_range(0, 1))
                        send(rand_pair($urandom_range(0, span - 1)));
                    else
                        send(make(CMD_LOAD_CRIT, $urandom_range(0, span - 1), $urandom,
                                  $urandom, $urandom_range(0, 1 << 21) - (1 << 20)));
                    sent++;
                end
            end
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: full-range fields, any slot, any command
                send(make($urandom_range(0, 3), $urandom_range(0, DEPTH - 1),
                          $urandom, $urandom, $urandom));
                sent++;
            end
            send(make(CMD_START, $urandom, $urandom, $urandom, $urandom));
            sent++;
            if (stress && sent > n_items / 2)
            begin
                drain();
                stress = 1'b0;
            end
        end
        random_sent += sent;
    endtask

    // receiver side
    initial
    begin
        int wait_n;
        pval_t exp_pv;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_n = long_hold ? 400 : $urandom_range(0, 7);
            long_hold = 1'b0;
            if (wait_n > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            if (pending_pvals.size() == 0)
                report($sformatf("unexpected result p=%0d idx=%0d",
                                 out_ch.p_value, out_ch.cross_index));
            else
            begin
                exp_pv = pending_pvals.pop_front();
                if (out_ch.p_value !== exp_pv.p)
                    report($sformatf("p_value %0d, want %0d", out_ch.p_value, exp_pv.p));
                if (out_ch.cross_index !== exp_pv.idx)
                    report($sformatf("cross_index %0d, want %0d",
                                     out_ch.cross_index, exp_pv.idx));
            end
        end
    end

    // stimulus
    initial
    begin
        cmd_item_t directed [$];
        cmd_item_t it;
        errors = 0;
        long_hold = 1'b0;
        random_sent = 0;
        pair_cnt = 11'd1;
        thr_cnt = 11'd1;
        inv_reg = INV_ONE;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.cmd <= '0;
        in_ch.slot <= '0;
        in_ch.h_value <= '0;
        in_ch.sigma_value <= '0;
        in_ch.crit_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the slots that searches use so none reads an unwritten entry
        for (int i = 0; i < FILL_SLOTS; i++)
        begin
            send(rand_pair(i));
            send(make(CMD_LOAD_CRIT, i, 0, 0, $urandom_range(0, 1 << 21) - (1 << 20)));
        end

        directed.push_back(make(CMD_LOAD_PAIR, 0, 32'h0001_0000, 32'h0, 32'h0));
        directed.push_back(make(CMD_LOAD_CRIT, 0, 32'h0, 32'h0, 32'h0));
        it = make(CMD_START, 0, 0, 0, 0);
        it.typed = 1'b1;
        it.p = '0;
        it.idx = '0;
        directed.push_back(it);
        directed.push_back(make(CMD_LOAD_PAIR, 0, 32'hFFFF_0000, 32'h0, 32'h0));
        it.p = PVAL_ONE;
        it.idx = 11'd1;
        directed.push_back(it);
        // theta exactly zero is not positive
        directed.push_back(make(CMD_LOAD_PAIR, 0, 32'h0, 32'h0, 32'h0));
        directed.push_back(it);
        directed.push_back(make(2'd3, 1023, '1, '1, '1));
        directed.push_back(make(CMD_LOAD_PAIR, 1023, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
        directed.push_back(make(CMD_LOAD_CRIT, 1023, 32'h0, 32'h0, 32'h8000_0000));
        directed.push_back(make(CMD_LOAD_PAIR, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        directed.push_back(make(CMD_LOAD_CRIT, 0, 32'h0, 32'h0, 32'h7FFF_FFFF));
        directed.push_back(make(CMD_START, 1023, 0, 0, 0));
        directed.push_back(make(CMD_LOAD_PAIR, 0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0));
        directed.push_back(make(CMD_LOAD_CRIT, 0, 32'h0, 32'h0, 32'h0001_0000));
        directed.push_back(make(CMD_START, 0, 0, 0, 0));
        directed.push_back(make(CMD_LOAD_CRIT, 0, 32'h0, 32'h0, 32'hFFFF_0000));
        directed.push_back(make(CMD_START, 0, 0, 0, 0));
        foreach (directed[i])
            send(directed[i]);

        // no critical values in use
        configure(1, 0, 65536);
        it = make(CMD_START, 0, 0, 0, 0);
        it.typed = 1'b1;
        it.p = PVAL_ONE;
        it.idx = '0;
        send(it);
        configure(16, 16, 131071);
        send(make(CMD_START, 0, 0, 0, 0));
        configure(0, 2047, 1);
        send(make(CMD_START, 0, 0, 0, 0));

        random_phase(0, 8, 65536, 40, 1'b0);
        random_phase(8, 0, 1, 30, 1'b0);
        random_phase(16, 2, 65536, 30, 1'b0);
        random_phase(2, 16, 131071, 30, 1'b0);
        random_phase(4, 16, 65536, 100, 1'b1);
        while (random_sent < RANDOM_ITEMS)
            random_phase($urandom_range(1, 16), $urandom_range(1, 16),
                         $urandom_range(1, 131071), 80, 1'b0);

        drain();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("threshold_crossing_pvalue_search_test: PASS");
        else
            $display("threshold_crossing_pvalue_search_test: FAIL");
        $finish;
    end

endmodule
